// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RHCA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RHCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rhca_pkg.sv =====
`default_nettype none
package rhca_pkg;

  // Fraction bits of the ramp position inside a 60 degree slope
  localparam int FRAC_BITS = 16;

  // Quotient bits of the hue and saturation dividers, one bit per stage
  localparam int QBITS = 8;

  // Cycles from a start transfer to its out_valid strobe
  localparam int LATENCY = QBITS + 11;

  // Mode register codes
  localparam logic [1:0] MODE_RGB2HLS = 2'd0;
  localparam logic [1:0] MODE_HLS2RGB = 2'd1;
  localparam logic [1:0] MODE_ADJUST  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_LPCT = 2'd1;
  localparam logic [1:0] CFG_SPCT = 2'd2;

  // Hue angles in units of 1/255 degree
  localparam logic [16:0] DEG60  = 17'd15300;
  localparam logic [16:0] DEG120 = 17'd30600;
  localparam logic [16:0] DEG180 = 17'd45900;
  localparam logic [16:0] DEG240 = 17'd61200;
  localparam logic [16:0] DEG360 = 17'd91800;

  // Ramp fraction: floor(x * 2^FRAC_BITS / DEG60) = (x * T_RECIP) >> T_SHIFT,
  // exact for x up to DEG60 since 2^T_SHIFT exceeds DEG60 squared
  localparam int T_SHIFT = 28;
  localparam int TREC_W  = FRAC_BITS + 15;
  localparam logic [TREC_W-1:0] T_RECIP = TREC_W'(
    ((64'd1 << (FRAC_BITS + T_SHIFT)) + 64'(DEG60) - 64'd1) / 64'(DEG60));

  // Percent scaling: floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT for x below 43690
  localparam logic [12:0] PCT_RECIP = 13'd5243;
  localparam int          PCT_SHIFT = 19;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
  } ctl_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pix_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] l;
    logic [7:0] s;
  } hls_t;

endpackage
`default_nettype wire

// ===== rtl/rhca_rgb2hls.sv =====
`default_nettype none
module rhca_rgb2hls (
  input  logic           clk,
  input  logic           rst_n,
  input  rhca_pkg::ctl_t in_ctl,
  input  rhca_pkg::pix_t in_pix,
  output rhca_pkg::ctl_t out_ctl,
  output rhca_pkg::pix_t out_pix,
  output rhca_pkg::hls_t out_hls
);

  localparam int QB = rhca_pkg::QBITS;

  typedef enum logic [1:0] {MAX_R, MAX_G, MAX_B} maxsel_t;

  // Stage 1: extremes and which channel is the maximum
  rhca_pkg::ctl_t ctl1_r;
  rhca_pkg::pix_t pix1_r;
  logic [7:0]     mx1_r;
  logic [7:0]     mn1_r;
  maxsel_t        sel1_r;
  logic [7:0]     mx_nxt;
  logic [7:0]     mn_nxt;
  maxsel_t        sel_nxt;

  // Divider stages, index 0 holds the prepared operands
  rhca_pkg::ctl_t ctl_r  [QB+1];
  rhca_pkg::pix_t pix_r  [QB+1];
  logic [7:0]     l_r    [QB+1];
  logic           grey_r [QB+1];
  logic [18:0]    hrem_r [QB+1];
  logic [10:0]    hdiv_r [QB+1];
  logic [QB-1:0]  hq_r   [QB+1];
  logic [15:0]    srem_r [QB+1];
  logic [7:0]     sdiv_r [QB+1];
  logic [QB-1:0]  sq_r   [QB+1];

  logic [8:0]  sum;
  logic [7:0]  d;
  logic [7:0]  den;
  logic [10:0] d6;
  logic [11:0] n_raw;
  logic [10:0] n;

  // Find max and min; on a tie the later channel is the maximum
  always_comb begin
    mx_nxt = in_pix.a;
    mn_nxt = in_pix.a;
    if (in_pix.b > mx_nxt) mx_nxt = in_pix.b;
    if (in_pix.c > mx_nxt) mx_nxt = in_pix.c;
    if (in_pix.b < mn_nxt) mn_nxt = in_pix.b;
    if (in_pix.c < mn_nxt) mn_nxt = in_pix.c;
    priority if (in_pix.c == mx_nxt) sel_nxt = MAX_B;
    else if (in_pix.b == mx_nxt) sel_nxt = MAX_G;
    else sel_nxt = MAX_R;
  end

  // Build dividend and divisor for hue and saturation
  always_comb begin
    sum = 9'(mx1_r) + 9'(mn1_r);
    d   = mx1_r - mn1_r;
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    d6  = (11'(d) << 2) + (11'(d) << 1);
    unique case (sel1_r)
      MAX_R:   n_raw = 12'(d6) + 12'(pix1_r.b) - 12'(pix1_r.c);
      MAX_G:   n_raw = (12'(d) << 1) + 12'(pix1_r.c) - 12'(pix1_r.a);
      MAX_B:   n_raw = (12'(d) << 2) + 12'(pix1_r.a) - 12'(pix1_r.b);
      default: n_raw = '0;
    endcase
    n = (n_raw >= 12'(d6)) ? 11'(n_raw - 12'(d6)) : n_raw[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r   <= '0;
      ctl_r[0] <= '0;
    end else begin
      ctl1_r   <= in_ctl;
      ctl_r[0] <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r    <= in_pix;
    mx1_r     <= mx_nxt;
    mn1_r     <= mn_nxt;
    sel1_r    <= sel_nxt;
    pix_r[0]  <= pix1_r;
    l_r[0]    <= sum[8:1];
    grey_r[0] <= (mx1_r == mn1_r);
    hrem_r[0] <= (19'(n) << 8) - 19'(n);
    hdiv_r[0] <= d6;
    hq_r[0]   <= '0;
    srem_r[0] <= (16'(d) << 8) - 16'(d);
    sdiv_r[0] <= den;
    sq_r[0]   <= '0;
  end

  // Restoring division, one quotient bit per stage, most significant first
  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int K = QB - 1 - i;
    logic [18:0] hsh;
    logic [15:0] ssh;
    logic        hge;
    logic        sge;

    assign hsh = 19'(hdiv_r[i]) << K;
    assign ssh = 16'(sdiv_r[i]) << K;
    assign hge = (hrem_r[i] >= hsh);
    assign sge = (srem_r[i] >= ssh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i+1] <= '0;
      end else begin
        ctl_r[i+1] <= ctl_r[i];
      end
    end

    always_ff @(posedge clk) begin
      pix_r[i+1]  <= pix_r[i];
      l_r[i+1]    <= l_r[i];
      grey_r[i+1] <= grey_r[i];
      hdiv_r[i+1] <= hdiv_r[i];
      sdiv_r[i+1] <= sdiv_r[i];
      hrem_r[i+1] <= hge ? (hrem_r[i] - hsh) : hrem_r[i];
      srem_r[i+1] <= sge ? (srem_r[i] - ssh) : srem_r[i];
      hq_r[i+1]   <= {hq_r[i][QB-2:0], hge};
      sq_r[i+1]   <= {sq_r[i][QB-2:0], sge};
    end
  end

  // Grey pixels get hue and saturation zero
  assign out_ctl   = ctl_r[QB];
  assign out_pix   = pix_r[QB];
  assign out_hls.h = grey_r[QB] ? 8'd0 : hq_r[QB];
  assign out_hls.l = l_r[QB];
  assign out_hls.s = grey_r[QB] ? 8'd0 : sq_r[QB];

endmodule
`default_nettype wire

// ===== rtl/rhca_adjust.sv =====
`default_nettype none
module rhca_adjust (
  input  logic               clk,
  input  logic               rst_n,
  input  rhca_pkg::ctl_t     in_ctl,
  input  rhca_pkg::pix_t     in_pix,
  input  rhca_pkg::hls_t     in_hls,
  input  logic signed [7:0]  lpct,
  input  logic signed [7:0]  spct,
  output rhca_pkg::ctl_t     out_ctl,
  output rhca_pkg::hls_t     out_cvt,
  output rhca_pkg::hls_t     out_fwd
);

  // Clamp to -100..100 and return {toward_zero, coefficient}
  function automatic logic [7:0] pct_coef(input logic signed [7:0] p);
    logic signed [7:0] c;
    if (p > 8'sd100) c = 8'sd100;
    else if (p < -8'sd100) c = -8'sd100;
    else c = p;
    if (c < 8'sd0) return {1'b1, 7'(8'sd100 + c)};
    else return {1'b0, c[6:0]};
  endfunction

  logic [7:0]  lc;
  logic [7:0]  sc;
  logic [7:0]  lop;
  logic [7:0]  sop;
  logic [14:0] lprod;
  logic [14:0] sprod;

  rhca_pkg::ctl_t ctl1_r;
  rhca_pkg::pix_t pix1_r;
  rhca_pkg::hls_t fwd1_r;
  logic [14:0]    lprod1_r;
  logic [14:0]    sprod1_r;
  logic [7:0]     lbase1_r;
  logic [7:0]     sbase1_r;

  logic [27:0]    lq;
  logic [27:0]    sq;
  rhca_pkg::hls_t cvt_nxt;

  rhca_pkg::ctl_t ctl2_r;
  rhca_pkg::hls_t cvt2_r;
  rhca_pkg::hls_t fwd2_r;

  // Scale the distance to 255 (positive) or the value itself (negative)
  always_comb begin
    lc    = pct_coef(lpct);
    sc    = pct_coef(spct);
    lop   = lc[7] ? in_hls.l : 8'(8'd255 - in_hls.l);
    sop   = sc[7] ? in_hls.s : 8'(8'd255 - in_hls.s);
    lprod = 15'(lop) * 15'(lc[6:0]);
    sprod = 15'(sop) * 15'(sc[6:0]);
  end

  // Divide by 100 and add the base; hls to rgb mode takes the input as is
  always_comb begin
    lq = 28'(lprod1_r) * 28'(rhca_pkg::PCT_RECIP);
    sq = 28'(sprod1_r) * 28'(rhca_pkg::PCT_RECIP);
    if (ctl1_r.mode == rhca_pkg::MODE_HLS2RGB) begin
      cvt_nxt = {pix1_r.a, pix1_r.b, pix1_r.c};
    end else begin
      cvt_nxt.h = fwd1_r.h;
      cvt_nxt.l = lbase1_r + lq[rhca_pkg::PCT_SHIFT +: 8];
      cvt_nxt.s = sbase1_r + sq[rhca_pkg::PCT_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r   <= in_pix;
    fwd1_r   <= in_hls;
    lprod1_r <= lprod;
    sprod1_r <= sprod;
    lbase1_r <= lc[7] ? 8'd0 : in_hls.l;
    sbase1_r <= sc[7] ? 8'd0 : in_hls.s;
    cvt2_r   <= cvt_nxt;
    fwd2_r   <= fwd1_r;
  end

  assign out_ctl = ctl2_r;
  assign out_cvt = cvt2_r;
  assign out_fwd = fwd2_r;

endmodule
`default_nettype wire

// ===== rtl/rhca_hls2rgb.sv =====
`default_nettype none
module rhca_hls2rgb (
  input  logic           clk,
  input  logic           rst_n,
  input  rhca_pkg::ctl_t in_ctl,
  input  rhca_pkg::hls_t in_cvt,
  input  rhca_pkg::hls_t in_fwd,
  output rhca_pkg::ctl_t out_ctl,
  output rhca_pkg::pix_t out_rgb,
  output rhca_pkg::hls_t out_fwd
);

  localparam int FB   = rhca_pkg::FRAC_BITS;
  localparam int TP_W = 14 + rhca_pkg::TREC_W;
  localparam int MP_W = 17 + FB;

  typedef enum logic [1:0] {RAMP_UP, RAMP_HI, RAMP_DN, RAMP_LO} ramp_t;

  // Stage 1
  rhca_pkg::ctl_t ctl1_r;
  rhca_pkg::hls_t fwd1_r;
  logic [16:0]    hue1_r;
  logic [7:0]     l1_r;
  logic [7:0]     s1_r;
  logic [15:0]    ls1_r;

  // Stage 2
  rhca_pkg::ctl_t ctl2_r;
  rhca_pkg::hls_t fwd2_r;
  logic           grey2_r;
  logic [7:0]     l2_r;
  logic [15:0]    rm1_2_r;
  logic [15:0]    rm2_2_r;
  logic [16:0]    rh2_r [3];
  logic [16:0]    l255;
  logic [16:0]    s255;
  logic [16:0]    rm1_nxt;
  logic [16:0]    rm2_nxt;
  logic [16:0]    rsum;
  logic [16:0]    rh_nxt [3];

  // Stage 3
  rhca_pkg::ctl_t ctl3_r;
  rhca_pkg::hls_t fwd3_r;
  logic           grey3_r;
  logic [7:0]     l3_r;
  logic [15:0]    rm1_3_r;
  logic [15:0]    rm2_3_r;
  logic [15:0]    diff3_r;
  ramp_t          cls3_r [3];
  logic [13:0]    x3_r [3];
  ramp_t          cls_nxt [3];
  logic [13:0]    x_nxt [3];

  // Stage 4
  rhca_pkg::ctl_t ctl4_r;
  rhca_pkg::hls_t fwd4_r;
  logic           grey4_r;
  logic [7:0]     l4_r;
  logic [15:0]    rm1_4_r;
  logic [15:0]    rm2_4_r;
  logic [15:0]    diff4_r;
  ramp_t          cls4_r [3];
  logic [TP_W-1:0] tprod4_r [3];

  // Stage 5
  rhca_pkg::ctl_t ctl5_r;
  rhca_pkg::hls_t fwd5_r;
  logic           grey5_r;
  logic [7:0]     l5_r;
  logic [15:0]    rm1_5_r;
  logic [15:0]    rm2_5_r;
  ramp_t          cls5_r [3];
  logic [MP_W-1:0] mprod5_r [3];

  // Stage 6
  rhca_pkg::ctl_t ctl6_r;
  rhca_pkg::hls_t fwd6_r;
  logic [7:0]     chan6_r [3];
  logic [16:0]    num [3];
  logic [16:0]    quo [3];

  // rm1 and rm2 scaled by 255*255; hue angle per channel, wrapped into 0..360
  always_comb begin
    l255 = (17'(l1_r) << 8) - 17'(l1_r);
    s255 = (17'(s1_r) << 8) - 17'(s1_r);
    if (l1_r <= 8'd127) begin
      rm2_nxt = l255 + 17'(ls1_r);
      rm1_nxt = l255 - 17'(ls1_r);
    end else begin
      rm2_nxt = l255 + s255 - 17'(ls1_r);
      rm1_nxt = l255 - s255 + 17'(ls1_r);
    end
    rsum      = hue1_r + rhca_pkg::DEG120;
    rh_nxt[0] = (rsum > rhca_pkg::DEG360) ? (rsum - rhca_pkg::DEG360) : rsum;
    rh_nxt[1] = hue1_r;
    rh_nxt[2] = (hue1_r >= rhca_pkg::DEG120) ? (hue1_r - rhca_pkg::DEG120)
                                             : (hue1_r + rhca_pkg::DEG240);
  end

  // Place each channel on the hue ramp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      priority if (rh2_r[k] < rhca_pkg::DEG60) begin
        cls_nxt[k] = RAMP_UP;
        x_nxt[k]   = rh2_r[k][13:0];
      end else if (rh2_r[k] < rhca_pkg::DEG180) begin
        cls_nxt[k] = RAMP_HI;
        x_nxt[k]   = '0;
      end else if (rh2_r[k] < rhca_pkg::DEG240) begin
        cls_nxt[k] = RAMP_DN;
        x_nxt[k]   = 14'(rhca_pkg::DEG240 - rh2_r[k]);
      end else begin
        cls_nxt[k] = RAMP_LO;
        x_nxt[k]   = '0;
      end
    end
  end

  // Blend on the slopes, then divide by 255 with a shift-add
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (cls5_r[k])
        RAMP_UP: num[k] = 17'(rm1_5_r) + 17'(mprod5_r[k][FB +: 16]);
        RAMP_DN: num[k] = 17'(rm1_5_r) + 17'(mprod5_r[k][FB +: 16]);
        RAMP_HI: num[k] = 17'(rm2_5_r);
        RAMP_LO: num[k] = 17'(rm1_5_r);
      endcase
      quo[k] = num[k] + (num[k] >> 8) + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    fwd1_r <= in_fwd;
    hue1_r <= 17'(in_cvt.h) * 17'd360;
    l1_r   <= in_cvt.l;
    s1_r   <= in_cvt.s;
    ls1_r  <= 16'(in_cvt.l) * 16'(in_cvt.s);
    // stage 2
    fwd2_r  <= fwd1_r;
    grey2_r <= (s1_r == 8'd0);
    l2_r    <= l1_r;
    rm1_2_r <= rm1_nxt[15:0];
    rm2_2_r <= rm2_nxt[15:0];
    // stage 3
    fwd3_r  <= fwd2_r;
    grey3_r <= grey2_r;
    l3_r    <= l2_r;
    rm1_3_r <= rm1_2_r;
    rm2_3_r <= rm2_2_r;
    diff3_r <= rm2_2_r - rm1_2_r;
    // stage 4
    fwd4_r  <= fwd3_r;
    grey4_r <= grey3_r;
    l4_r    <= l3_r;
    rm1_4_r <= rm1_3_r;
    rm2_4_r <= rm2_3_r;
    diff4_r <= diff3_r;
    // stage 5
    fwd5_r  <= fwd4_r;
    grey5_r <= grey4_r;
    l5_r    <= l4_r;
    rm1_5_r <= rm1_4_r;
    rm2_5_r <= rm2_4_r;
    // stage 6, then the per-channel registers of stages 2 to 6
    fwd6_r  <= fwd5_r;
    for (int k = 0; k < 3; k++) begin
      rh2_r[k]    <= rh_nxt[k];
      cls3_r[k]   <= cls_nxt[k];
      x3_r[k]     <= x_nxt[k];
      cls4_r[k]   <= cls3_r[k];
      tprod4_r[k] <= TP_W'(x3_r[k]) * TP_W'(rhca_pkg::T_RECIP);
      cls5_r[k]   <= cls4_r[k];
      mprod5_r[k] <= MP_W'(diff4_r)
                     * MP_W'(tprod4_r[k][rhca_pkg::T_SHIFT +: FB + 1]);
      // zero saturation gives grey at the lightness byte
      chan6_r[k]  <= grey5_r ? l5_r : quo[k][15:8];
    end
  end

  assign out_ctl   = ctl6_r;
  assign out_rgb.a = chan6_r[0];
  assign out_rgb.b = chan6_r[1];
  assign out_rgb.c = chan6_r[2];
  assign out_fwd   = fwd6_r;

endmodule
`default_nettype wire

// ===== rtl/rgb_hls_color_convert_adjust.sv =====
// Throughput: one pixel per clock; busy is high in reset and drops in the cycle after reset is released.
// Depth: 10 stages for rgb to hls (8 of them the hue and saturation dividers),
// 2 for the percent adjust, 6 for hls to rgb and 1 output register.
// Synchronous active-low reset clears valid bits and the mode and percent
// registers to 0; results leave without backpressure.
`default_nettype none
`include "assert_macros.svh"
module rgb_hls_color_convert_adjust (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_chan_a,
  input  logic [7:0] in_chan_b,
  input  logic [7:0] in_chan_c,
  output logic       out_valid,
  output logic [7:0] out_res_a,
  output logic [7:0] out_res_b,
  output logic [7:0] out_res_c,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic              busy_r;
  logic [1:0]        mode_r;
  logic signed [7:0] lpct_r;
  logic signed [7:0] spct_r;

  rhca_pkg::ctl_t in_ctl;
  rhca_pkg::pix_t in_pix;

  rhca_pkg::ctl_t fw_ctl;
  rhca_pkg::pix_t fw_pix;
  rhca_pkg::hls_t fw_hls;

  rhca_pkg::ctl_t adj_ctl;
  rhca_pkg::hls_t adj_cvt;
  rhca_pkg::hls_t adj_fwd;

  rhca_pkg::ctl_t bw_ctl;
  rhca_pkg::pix_t bw_rgb;
  rhca_pkg::hls_t bw_fwd;

  logic           out_valid_r;
  rhca_pkg::pix_t res_r;
  rhca_pkg::pix_t res_nxt;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  assign in_ctl.vld  = start & ~busy_r;
  assign in_ctl.mode = mode_r;
  assign in_pix      = {in_chan_a, in_chan_b, in_chan_c};

  // Hold busy through reset only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rhca_pkg::MODE_RGB2HLS;
      lpct_r <= '0;
      spct_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rhca_pkg::CFG_MODE: mode_r <= cfg_data[1:0];
        rhca_pkg::CFG_LPCT: lpct_r <= cfg_data;
        rhca_pkg::CFG_SPCT: spct_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rhca_rgb2hls u_rgb2hls (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (in_ctl),
    .in_pix  (in_pix),
    .out_ctl (fw_ctl),
    .out_pix (fw_pix),
    .out_hls (fw_hls)
  );

  rhca_adjust u_adjust (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (fw_ctl),
    .in_pix  (fw_pix),
    .in_hls  (fw_hls),
    .lpct    (lpct_r),
    .spct    (spct_r),
    .out_ctl (adj_ctl),
    .out_cvt (adj_cvt),
    .out_fwd (adj_fwd)
  );

  rhca_hls2rgb u_hls2rgb (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (adj_ctl),
    .in_cvt  (adj_cvt),
    .in_fwd  (adj_fwd),
    .out_ctl (bw_ctl),
    .out_rgb (bw_rgb),
    .out_fwd (bw_fwd)
  );

  // Pick rgb or hls per the mode that traveled with the pixel
  always_comb begin
    unique case (bw_ctl.mode)
      rhca_pkg::MODE_HLS2RGB: res_nxt = bw_rgb;
      rhca_pkg::MODE_ADJUST:  res_nxt = bw_rgb;
      default:                res_nxt = {bw_fwd.h, bw_fwd.l, bw_fwd.s};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bw_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res_a = res_r.a;
  assign out_res_b = res_r.b;
  assign out_res_c = res_r.c;

  // Every strobe traces back to a start transfer a fixed latency earlier
  `RHCA_ASSERT_IMPL(a_strobe_has_start, out_valid, $past(start && !busy, rhca_pkg::LATENCY), "result strobe without matching start transfer")

  // Grey pixels in rgb to hls mode come back with hue and saturation zero
  `RHCA_ASSERT_IMPL(a_grey_zero, $past(start && !busy && in_chan_a == in_chan_b && in_chan_b == in_chan_c && mode_r == rhca_pkg::MODE_RGB2HLS, rhca_pkg::LATENCY), !out_valid || (out_res_a == 8'd0 && out_res_c == 8'd0), "grey pixel gave nonzero hue or saturation")

  // Busy drops right after reset is released
  `RHCA_ASSERT_NEXT(a_busy_free, rst_n, !busy, "busy high outside reset")

endmodule
`default_nettype wire

// ===== bench/rhca_checker.sv =====
`timescale 1ns / 1ps
module rhca_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] in_chan_a,
  input  logic [7:0] in_chan_b,
  input  logic [7:0] in_chan_c,
  input  logic       out_valid,
  input  logic [7:0] out_res_a,
  input  logic [7:0] out_res_b,
  input  logic [7:0] out_res_c,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         pixels_seen
);

  logic [1:0]      cur_mode;
  int              cur_lpct;
  int              cur_spct;
  rhca_pkg::pix_t  pixel_q[$];

  // Mirror of the configuration registers
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode <= rhca_pkg::MODE_RGB2HLS;
      cur_lpct <= 0;
      cur_spct <= 0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rhca_pkg::CFG_MODE: cur_mode <= cfg_data[1:0];
        rhca_pkg::CFG_LPCT: cur_lpct <= int'($signed(cfg_data));
        rhca_pkg::CFG_SPCT: cur_spct <= int'($signed(cfg_data));
        default: ;
      endcase
    end
  end

  function automatic rhca_pkg::hls_t to_hls(input logic [7:0] r, g, b);
    rhca_pkg::hls_t o;
    int mx, mn, sum, d, den, n;
    mx = int'(r); mn = int'(r);
    if (g > mx) mx = int'(g);
    if (b > mx) mx = int'(b);
    if (g < mn) mn = int'(g);
    if (b < mn) mn = int'(b);
    sum = mx + mn;
    o.l = 8'(sum >> 1);
    if (mx == mn) begin
      o.h = 8'd0; o.s = 8'd0;
      return o;
    end
    d = mx - mn;
    den = (sum <= 255) ? sum : 510 - sum;
    o.s = 8'((d * 255) / den);
    n = 0;
    if (r == mx) n = 6 * d + int'(g) - int'(b);
    if (g == mx) n = 2 * d + int'(b) - int'(r);
    if (b == mx) n = 4 * d + int'(r) - int'(g);
    if (n >= 6 * d) n -= 6 * d;
    o.h = 8'((n * 255) / (6 * d));
    return o;
  endfunction

  function automatic logic [7:0] ramp(input longint lo, hi, input longint rh);
    longint t;
    if (rh > 91800) rh -= 91800;
    else if (rh < 0) rh += 91800;
    if (rh < 15300) t = (rh << rhca_pkg::FRAC_BITS) / 15300;
    else if (rh < 45900) return 8'(hi / 255);
    else if (rh < 61200) t = ((61200 - rh) << rhca_pkg::FRAC_BITS) / 15300;
    else return 8'(lo / 255);
    return 8'(((lo << rhca_pkg::FRAC_BITS) + (hi - lo) * t)
              / (longint'(255) << rhca_pkg::FRAC_BITS));
  endfunction

  function automatic rhca_pkg::pix_t to_rgb(input logic [7:0] h, l, s);
    rhca_pkg::pix_t o;
    longint m1, m2, hue;
    if (s == 0) begin
      o.a = l; o.b = l; o.c = l;
      return o;
    end
    if (l <= 127) m2 = longint'(l) * (255 + longint'(s));
    else m2 = 255 * (longint'(l) + longint'(s)) - longint'(l) * longint'(s);
    m1 = 510 * longint'(l) - m2;
    hue = longint'(h) * 360;
    o.a = ramp(m1, m2, hue + 30600);
    o.b = ramp(m1, m2, hue);
    o.c = ramp(m1, m2, hue - 30600);
    return o;
  endfunction

  function automatic logic [7:0] shift_toward(input logic [7:0] v, input int p);
    if (p > 100) p = 100;
    if (p < -100) p = -100;
    if (p > 0) return 8'(int'(v) + ((255 - int'(v)) * p) / 100);
    if (p < 0) return 8'((int'(v) * (100 + p)) / 100);
    return v;
  endfunction

  function automatic rhca_pkg::pix_t convert_pixel(input rhca_pkg::pix_t p);
    rhca_pkg::hls_t q;
    rhca_pkg::pix_t o;
    if (cur_mode == rhca_pkg::MODE_HLS2RGB) return to_rgb(p.a, p.b, p.c);
    q = to_hls(p.a, p.b, p.c);
    if (cur_mode == rhca_pkg::MODE_ADJUST)
      return to_rgb(q.h, shift_toward(q.l, cur_lpct), shift_toward(q.s, cur_spct));
    o.a = q.h; o.b = q.l; o.c = q.s;
    return o;
  endfunction

  // Predict on each input transfer, compare on each result strobe
  always @(posedge clk) begin
    rhca_pkg::pix_t want;
    if (!rst_n) begin
      fail_count  <= 0;
      pixels_seen <= 0;
      pending     <= 0;
      pixel_q.delete();
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h %h %h",
                                        out_res_a, out_res_b, out_res_c);
        end else begin
          want = pixel_q.pop_front();
          if (want != {out_res_a, out_res_b, out_res_c}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: want %h %h %h got %h %h %h", want.a, want.b,
                       want.c, out_res_a, out_res_b, out_res_c);
          end
        end
      end
      if (start && !busy) begin
        pixel_q.push_back(convert_pixel({in_chan_a, in_chan_b, in_chan_c}));
        pixels_seen <= pixels_seen + 1;
      end
      pending <= pixel_q.size();
    end
  end

endmodule

// ===== bench/tb_rgb_hls_color_convert_adjust.sv =====
`timescale 1ns / 1ps
module tb_rgb_hls_color_convert_adjust;

  localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;
  localparam logic [1:0] MODE_SPARE       = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_chan_a, in_chan_b, in_chan_c;
  logic       out_valid;
  logic [7:0] out_res_a, out_res_b, out_res_c;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count, pending, pixels_seen;
  int         cycle_count;

  rgb_hls_color_convert_adjust u_top (.*);
  rhca_checker u_check (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Hard stop if the pipeline hangs
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("[rgb_hls_color_convert_adjust] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // Drive one pixel after an optional random gap with start low, holding start until the transfer
  task automatic send_pixel(input logic [7:0] a, b, c, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start <= 0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    start <= 1; in_chan_a <= a; in_chan_b <= b; in_chan_c <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (rhca_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic directed_set;
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 0);
    send_pixel(255, 255, 0, 0);
    send_pixel(0, 255, 255, 0);
    send_pixel(255, 0, 255, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(255, 0, 1, 0);
    send_pixel(0, 128, 255, 0);
    send_pixel(1, 254, 127, 0);
    send_pixel(200, 100, 50, 0);
  endtask

  initial begin
    int mode_sel, n;
    logic [7:0] pct_pick[8];
    pct_pick = '{8'd0, 8'd100, 8'h9c, 8'd127, 8'h80, 8'd50, 8'hce, 8'd1};
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = rhca_pkg::CFG_MODE; cfg_data = 0;
    in_chan_a = 0; in_chan_b = 0; in_chan_c = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed corners in each mode, percents at extremes in adjust mode
    directed_set();
    drain();
    write_reg(rhca_pkg::CFG_MODE, rhca_pkg::MODE_HLS2RGB);
    directed_set();
    drain();
    write_reg(rhca_pkg::CFG_MODE, rhca_pkg::MODE_ADJUST);
    write_reg(rhca_pkg::CFG_LPCT, 8'd100);
    write_reg(rhca_pkg::CFG_SPCT, 8'h9c);
    directed_set();
    drain();
    write_reg(rhca_pkg::CFG_LPCT, 8'h80);
    write_reg(rhca_pkg::CFG_SPCT, 8'd127);
    directed_set();
    drain();
    write_reg(rhca_pkg::CFG_MODE, MODE_SPARE);
    directed_set();
    drain();
    write_reg(CFG_INDEX_UNUSED, 8'hff);

    // Random phases with changing settings; last phase without gaps
    for (int ph = 0; ph < 12; ph++) begin
      mode_sel = $urandom_range(0, 3);
      write_reg(rhca_pkg::CFG_MODE, 2'(mode_sel));
      write_reg(rhca_pkg::CFG_LPCT, $urandom_range(0, 1) ? pct_pick[$urandom_range(0, 7)]
                                                         : 8'($urandom));
      write_reg(rhca_pkg::CFG_SPCT, $urandom_range(0, 1) ? pct_pick[$urandom_range(0, 7)]
                                                         : 8'($urandom));
      n = 100;
      for (int i = 0; i < n; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), ph < 11);
      drain();
    end

    $display("covered %0d pixels in all modes, percent registers at extremes", pixels_seen);
    if (fail_count == 0) begin
      $display("[rgb_hls_color_convert_adjust] OK");
    end else begin
      $display("[rgb_hls_color_convert_adjust] ERROR");
    end
    $finish;
  end

endmodule
